/* src/fixed_point_alu_assert.svh */
// Assertion macros for the fixed-point ALU. Define ASSERT_OFF to drop them.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication under an active-low reset.
`define FPA_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fixed_point_alu: implication check failed");
// Next-cycle implication under an active-low reset.
`define FPA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fixed_point_alu: next-cycle check failed");
`else
`define FPA_ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define FPA_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* src/fpa_pkg.sv */
package fpa_pkg;

    localparam int FRAC_BITS_DEF   = 8;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DATA_W          = 32;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } fpa_op_t;

    // How the tail of the pipeline finishes an item.
    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_MUL,
        KIND_DIV,
        KIND_DBZ
    } fpa_kind_t;

    typedef struct packed {
        fpa_kind_t kind;
        logic      neg;
        logic      cmp;
        logic      ovf;
    } fpa_ctrl_t;

    typedef struct packed {
        fpa_op_t                  operation;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } fpa_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     compare_true;
        logic                     overflow;
        logic                     divide_by_zero;
    } fpa_out_t;

endpackage

/* src/fixed_point_alu.sv */
// Signed fixed-point ALU for raw Q(W-F).F operands, Q24.8 with the default
// VALUE_WIDTH = 32 and FRAC_BITS = 8 (VALUE_WIDTH above 32 behaves as 32,
// the width of the ports). Each transaction carries an operation code and two
// raw operands and yields one result transaction: add, subtract, increment,
// decrement and integer-to-fixed wrap; multiply gives (a*b)>>F and divide gives
// (a<<F)/b, both rounded to nearest with ties away from zero and saturated,
// with overflow set on saturation; divide by zero returns 0 with its own
// flag; the six comparisons set compare_true and return 0; min, max and
// fixed-to-integer (arithmetic right shift) complete the set. The block takes
// one transaction per clock while m_ready is high, and every operation passes
// through the same stages: one decode stage, three multiplier stages (product,
// round, saturate), one restoring-division stage per quotient bit (W + F of
// them) and one rounding/saturating output stage. Each stage holds its own
// valid bit and takes new data whenever it is empty or moving, so s_ready
// stays high while m_ready is high, and bubbles are squeezed out while the
// output stalls.
`include "fixed_point_alu_assert.svh"

module fixed_point_alu #(
    parameter int VALUE_WIDTH = fpa_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fpa_pkg::fpa_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output fpa_pkg::fpa_out_t m_payload
);
    import fpa_pkg::*;

    localparam int DW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam int QW = DW + FRAC_BITS;

    // decode -> multiplier
    logic          dec_valid, dec_ready;
    fpa_ctrl_t     dec_ctrl;
    logic [DW-1:0] dec_res, dec_mag_a, dec_mag_b;

    // multiplier -> divider chain
    logic          mul_valid;
    fpa_ctrl_t     mul_ctrl;
    logic [DW-1:0] mul_res, mul_mag_a, mul_mag_b;

    // divider chain taps, index 0 is the chain input
    logic [QW:0]   sv;
    logic [QW:0]   sr;
    fpa_ctrl_t     sc    [QW+1];
    logic [DW-1:0] sres  [QW+1];
    logic [DW-1:0] srem  [QW+1];
    logic [QW-1:0] snumq [QW+1];
    logic [DW-1:0] sden  [QW+1];

    // Decode: narrow the operands, finish every simple operation,
    // and form the magnitudes and result sign for multiply and divide.
    fpa_decode #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_payload),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_ctrl  (dec_ctrl),
        .out_res   (dec_res),
        .out_mag_a (dec_mag_a),
        .out_mag_b (dec_mag_b)
    );

    // Multiply, round and saturate; other items pass along untouched.
    fpa_mul #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_ctrl   (dec_ctrl),
        .in_res    (dec_res),
        .in_mag_a  (dec_mag_a),
        .in_mag_b  (dec_mag_b),
        .out_valid (mul_valid),
        .out_ready (sr[0]),
        .out_ctrl  (mul_ctrl),
        .out_res   (mul_res),
        .out_mag_a (mul_mag_a),
        .out_mag_b (mul_mag_b)
    );

    // Seed the divider: numerator |a| << F, divisor |b|, remainder zero.
    assign sv[0]    = mul_valid;
    assign sc[0]    = mul_ctrl;
    assign sres[0]  = mul_res;
    assign srem[0]  = '0;
    assign snumq[0] = QW'(mul_mag_a) << FRAC_BITS;
    assign sden[0]  = mul_mag_b;

    // One quotient bit per stage, most significant first.
    for (genvar i = 0; i < QW; i++) begin : g_div
        fpa_div_step #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sv[i]),
            .in_ready  (sr[i]),
            .in_ctrl   (sc[i]),
            .in_res    (sres[i]),
            .in_rem    (srem[i]),
            .in_numq   (snumq[i]),
            .in_den    (sden[i]),
            .out_valid (sv[i+1]),
            .out_ready (sr[i+1]),
            .out_ctrl  (sc[i+1]),
            .out_res   (sres[i+1]),
            .out_rem   (srem[i+1]),
            .out_numq  (snumq[i+1]),
            .out_den   (sden[i+1])
        );
    end

    // Round and saturate the quotient, merge flags, hold the result
    // in the output register until the transaction is taken.
    fpa_div_final #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_final (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sv[QW]),
        .in_ready  (sr[QW]),
        .in_ctrl   (sc[QW]),
        .in_res    (sres[QW]),
        .in_rem    (srem[QW]),
        .in_quo    (snumq[QW]),
        .in_den    (sden[QW]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_payload)
    );

    // A ready sink lets every stage advance, so the input never blocks.
    `FPA_ASSERT_IMPLIES(a_ready_flows, aclk, aresetn, m_ready, s_ready)
    // Divide by zero is only decoded for a zero divisor.
    `FPA_ASSERT_IMPLIES(a_dbz_zero_den, aclk, aresetn, dec_valid && (dec_ctrl.kind == KIND_DBZ), dec_mag_b == '0)
    // Restoring division leaves a remainder below the divisor.
    `FPA_ASSERT_IMPLIES(a_rem_below_den, aclk, aresetn, sv[QW] && (sc[QW].kind == KIND_DIV), srem[QW] < sden[QW])
    // A divide-by-zero result is clean zero with no overflow.
    `FPA_ASSERT_IMPLIES(a_dbz_clean, aclk, aresetn, m_valid && m_payload.divide_by_zero, (m_payload.result == '0) && !m_payload.overflow)

endmodule

/* src/fpa_decode.sv */
module fpa_decode #(
    parameter int VALUE_WIDTH = fpa_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = fpa_pkg::FRAC_BITS_DEF,
    localparam int DW = (VALUE_WIDTH < fpa_pkg::DATA_W) ? VALUE_WIDTH : fpa_pkg::DATA_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  fpa_pkg::fpa_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output fpa_pkg::fpa_ctrl_t out_ctrl,
    output logic [DW-1:0]     out_res,
    output logic [DW-1:0]     out_mag_a,
    output logic [DW-1:0]     out_mag_b
);
    import fpa_pkg::*;

    logic signed [DW-1:0] a_n;
    logic signed [DW-1:0] b_n;
    logic signed [DW-1:0] res_next;
    logic [DW-1:0]        mag_a_next;
    logic [DW-1:0]        mag_b_next;
    fpa_ctrl_t            ctrl_next;

    logic                 valid_reg;
    fpa_ctrl_t            ctrl_reg;
    logic [DW-1:0]        res_reg;
    logic [DW-1:0]        mag_a_reg;
    logic [DW-1:0]        mag_b_reg;

    always_comb begin
        a_n        = in_data.operand_a[DW-1:0];
        b_n        = in_data.operand_b[DW-1:0];
        mag_a_next = a_n[DW-1] ? unsigned'(-a_n) : unsigned'(a_n);
        mag_b_next = b_n[DW-1] ? unsigned'(-b_n) : unsigned'(b_n);
        res_next       = '0;
        ctrl_next.kind = KIND_SIMPLE;
        ctrl_next.neg  = a_n[DW-1] ^ b_n[DW-1];
        ctrl_next.cmp  = 1'b0;
        ctrl_next.ovf  = 1'b0;
        unique case (in_data.operation)
            OP_ADD:      res_next = a_n + b_n;
            OP_SUB:      res_next = a_n - b_n;
            OP_MUL:      ctrl_next.kind = KIND_MUL;
            OP_DIV:      ctrl_next.kind = (b_n == '0) ? KIND_DBZ : KIND_DIV;
            OP_GT:       ctrl_next.cmp = (a_n > b_n);
            OP_LT:       ctrl_next.cmp = (a_n < b_n);
            OP_GE:       ctrl_next.cmp = (a_n >= b_n);
            OP_LE:       ctrl_next.cmp = (a_n <= b_n);
            OP_EQ:       ctrl_next.cmp = (a_n == b_n);
            OP_NE:       ctrl_next.cmp = (a_n != b_n);
            OP_MIN:      res_next = (a_n < b_n) ? a_n : b_n;
            OP_MAX:      res_next = (a_n > b_n) ? a_n : b_n;
            OP_INC:      res_next = a_n + DW'(1);
            OP_DEC:      res_next = a_n - DW'(1);
            OP_FROM_INT: res_next = a_n << FRAC_BITS;
            OP_TO_INT:   res_next = a_n >>> FRAC_BITS;
            default:     res_next = '0;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctrl_reg  <= ctrl_next;
            res_reg   <= res_next;
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_res   = res_reg;
    assign out_mag_a = mag_a_reg;
    assign out_mag_b = mag_b_reg;

endmodule

/* src/fpa_mul.sv */
module fpa_mul #(
    parameter int VALUE_WIDTH = fpa_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = fpa_pkg::FRAC_BITS_DEF,
    localparam int DW = (VALUE_WIDTH < fpa_pkg::DATA_W) ? VALUE_WIDTH : fpa_pkg::DATA_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fpa_pkg::fpa_ctrl_t in_ctrl,
    input  logic [DW-1:0]      in_res,
    input  logic [DW-1:0]      in_mag_a,
    input  logic [DW-1:0]      in_mag_b,
    output logic               out_valid,
    input  logic               out_ready,
    output fpa_pkg::fpa_ctrl_t out_ctrl,
    output logic [DW-1:0]      out_res,
    output logic [DW-1:0]      out_mag_a,
    output logic [DW-1:0]      out_mag_b
);
    import fpa_pkg::*;

    localparam int PW = 2 * DW;
    localparam logic [PW-1:0] HALF =
        (FRAC_BITS > 0) ? (PW'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;
    localparam logic [PW-1:0] POS_LIM = PW'((64'(1) << (DW - 1)) - 64'(1));
    localparam logic [PW-1:0] NEG_LIM = PW'(64'(1) << (DW - 1));
    localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};

    logic rdy1, rdy2, rdy3;

    // product stage
    logic          v1_reg;
    fpa_ctrl_t     ctrl1_reg;
    logic [DW-1:0] res1_reg, mag_a1_reg, mag_b1_reg;
    logic [PW-1:0] prod1_reg;
    logic [PW-1:0] prod_next;

    // rounding stage
    logic          v2_reg;
    fpa_ctrl_t     ctrl2_reg;
    logic [DW-1:0] res2_reg, mag_a2_reg, mag_b2_reg;
    logic [PW-1:0] qm2_reg;
    logic [PW-1:0] qm_next;

    // saturation stage
    logic          v3_reg;
    fpa_ctrl_t     ctrl3_reg;
    logic [DW-1:0] res3_reg, mag_a3_reg, mag_b3_reg;
    fpa_ctrl_t     ctrl3_next;
    logic [DW-1:0] res3_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign prod_next = PW'(in_mag_a) * PW'(in_mag_b);
    assign qm_next   = (prod1_reg + HALF) >> FRAC_BITS;

    always_comb begin
        ctrl3_next = ctrl2_reg;
        res3_next  = res2_reg;
        if (ctrl2_reg.kind == KIND_MUL) begin
            if (ctrl2_reg.neg) begin
                if (qm2_reg > NEG_LIM) begin
                    ctrl3_next.ovf = 1'b1;
                    res3_next      = MIN_NEG;
                end else begin
                    res3_next = -qm2_reg[DW-1:0];
                end
            end else begin
                if (qm2_reg > POS_LIM) begin
                    ctrl3_next.ovf = 1'b1;
                    res3_next      = MAX_POS;
                end else begin
                    res3_next = qm2_reg[DW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            ctrl1_reg  <= in_ctrl;
            res1_reg   <= in_res;
            mag_a1_reg <= in_mag_a;
            mag_b1_reg <= in_mag_b;
            prod1_reg  <= prod_next;
        end
        if (rdy2 && v1_reg) begin
            ctrl2_reg  <= ctrl1_reg;
            res2_reg   <= res1_reg;
            mag_a2_reg <= mag_a1_reg;
            mag_b2_reg <= mag_b1_reg;
            qm2_reg    <= qm_next;
        end
        if (rdy3 && v2_reg) begin
            ctrl3_reg  <= ctrl3_next;
            res3_reg   <= res3_next;
            mag_a3_reg <= mag_a2_reg;
            mag_b3_reg <= mag_b2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_ctrl  = ctrl3_reg;
    assign out_res   = res3_reg;
    assign out_mag_a = mag_a3_reg;
    assign out_mag_b = mag_b3_reg;

endmodule

/* src/fpa_div_step.sv */
module fpa_div_step #(
    parameter int VALUE_WIDTH = fpa_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = fpa_pkg::FRAC_BITS_DEF,
    localparam int DW = (VALUE_WIDTH < fpa_pkg::DATA_W) ? VALUE_WIDTH : fpa_pkg::DATA_W,
    localparam int QW = DW + FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fpa_pkg::fpa_ctrl_t in_ctrl,
    input  logic [DW-1:0]      in_res,
    input  logic [DW-1:0]      in_rem,
    input  logic [QW-1:0]      in_numq,
    input  logic [DW-1:0]      in_den,
    output logic               out_valid,
    input  logic               out_ready,
    output fpa_pkg::fpa_ctrl_t out_ctrl,
    output logic [DW-1:0]      out_res,
    output logic [DW-1:0]      out_rem,
    output logic [QW-1:0]      out_numq,
    output logic [DW-1:0]      out_den
);
    import fpa_pkg::*;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] numq_next;

    logic          valid_reg;
    fpa_ctrl_t     ctrl_reg;
    logic [DW-1:0] res_reg, rem_reg, den_reg;
    logic [QW-1:0] numq_reg;

    // Bring down the next numerator bit, subtract when the divisor fits,
    // shift the quotient bit into the vacated low end.
    assign trial     = {in_rem, in_numq[QW-1]};
    assign diff      = trial - {1'b0, in_den};
    assign fits      = (trial >= {1'b0, in_den});
    assign rem_next  = fits ? diff[DW-1:0] : trial[DW-1:0];
    assign numq_next = {in_numq[QW-2:0], fits};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctrl_reg <= in_ctrl;
            res_reg  <= in_res;
            rem_reg  <= rem_next;
            numq_reg <= numq_next;
            den_reg  <= in_den;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_res   = res_reg;
    assign out_rem   = rem_reg;
    assign out_numq  = numq_reg;
    assign out_den   = den_reg;

endmodule

/* src/fpa_div_final.sv */
module fpa_div_final #(
    parameter int VALUE_WIDTH = fpa_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = fpa_pkg::FRAC_BITS_DEF,
    localparam int DW = (VALUE_WIDTH < fpa_pkg::DATA_W) ? VALUE_WIDTH : fpa_pkg::DATA_W,
    localparam int QW = DW + FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fpa_pkg::fpa_ctrl_t in_ctrl,
    input  logic [DW-1:0]      in_res,
    input  logic [DW-1:0]      in_rem,
    input  logic [QW-1:0]      in_quo,
    input  logic [DW-1:0]      in_den,
    output logic               out_valid,
    input  logic               out_ready,
    output fpa_pkg::fpa_out_t  out_data
);
    import fpa_pkg::*;

    localparam logic [QW:0]   POS_LIM = (QW+1)'((64'(1) << (DW - 1)) - 64'(1));
    localparam logic [QW:0]   NEG_LIM = (QW+1)'(64'(1) << (DW - 1));
    localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};

    logic          round_up;
    logic [QW:0]   quo_rnd;
    logic [DW-1:0] res_w;
    logic          ovf_w;
    fpa_out_t      out_next;

    logic          valid_reg;
    fpa_out_t      out_reg;

    // Round half away from zero on the magnitude: bump when 2*rem >= den.
    assign round_up = ({in_rem, 1'b0} >= {1'b0, in_den});
    assign quo_rnd  = {1'b0, in_quo} + (QW+1)'(round_up);

    always_comb begin
        res_w = in_res;
        ovf_w = 1'b0;
        unique case (in_ctrl.kind)
            KIND_MUL: ovf_w = in_ctrl.ovf;
            KIND_DBZ: res_w = '0;
            KIND_DIV: begin
                if (in_ctrl.neg) begin
                    if (quo_rnd > NEG_LIM) begin
                        ovf_w = 1'b1;
                        res_w = MIN_NEG;
                    end else begin
                        res_w = -quo_rnd[DW-1:0];
                    end
                end else begin
                    if (quo_rnd > POS_LIM) begin
                        ovf_w = 1'b1;
                        res_w = MAX_POS;
                    end else begin
                        res_w = quo_rnd[DW-1:0];
                    end
                end
            end
            default: res_w = in_res;
        endcase
        out_next.result         = DATA_W'(signed'(res_w));
        out_next.compare_true   = in_ctrl.cmp;
        out_next.overflow       = ovf_w;
        out_next.divide_by_zero = (in_ctrl.kind == KIND_DBZ);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = out_reg;

endmodule

/* tb/tb_fixed_point_alu.sv */
`timescale 1ns / 100ps

module tb_fixed_point_alu;
    import fpa_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int LATENCY     = DATA_W + FRAC + 5;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 20000;

    // Tracks the expected ALU results in order of acceptance and checks each
    // returned transaction against the oldest one.
    class alu_result_tracker;
        fpa_out_t    pending_results[$];
        int unsigned mismatches = 0;

        // Apply the sign and clamp a magnitude to the signed 32-bit range.
        function logic signed [DATA_W-1:0] clamp_signed(input logic [63:0] mag,
                                                        input bit neg,
                                                        output bit ovf);
            logic [63:0] pos_lim;
            pos_lim = 64'h0000_0000_7FFF_FFFF;
            ovf = 1'b0;
            if (neg) begin
                if (mag > pos_lim + 64'd1) begin
                    ovf = 1'b1;
                    mag = pos_lim + 64'd1;
                end
                return DATA_W'(64'd0 - mag);
            end
            if (mag > pos_lim) begin
                ovf = 1'b1;
                mag = pos_lim;
            end
            return mag[DATA_W-1:0];
        endfunction

        function fpa_out_t alu_result_of(input fpa_in_t x);
            fpa_out_t                 r;
            logic signed [DATA_W-1:0] a;
            logic signed [DATA_W-1:0] b;
            logic [63:0]              mag_a;
            logic [63:0]              mag_b;
            logic [63:0]              num;
            bit                       neg;
            bit                       ovf;
            r = '0;
            a = x.operand_a;
            b = x.operand_b;
            mag_a = a[DATA_W-1] ? 64'(-longint'(a)) : 64'(longint'(a));
            mag_b = b[DATA_W-1] ? 64'(-longint'(b)) : 64'(longint'(b));
            neg = a[DATA_W-1] ^ b[DATA_W-1];
            ovf = 1'b0;
            case (x.operation)
                OP_ADD: r.result = a + b;
                OP_SUB: r.result = a - b;
                OP_MUL: begin
                    // exact product, round half away from zero on the magnitude
                    r.result = clamp_signed((mag_a * mag_b + (64'd1 << (FRAC - 1))) >> FRAC,
                                            neg, ovf);
                    r.overflow = ovf;
                end
                OP_DIV: begin
                    if (b == 0) begin
                        r.divide_by_zero = 1'b1;
                    end else begin
                        num = mag_a << FRAC;
                        r.result = clamp_signed((64'd2 * num + mag_b) / (64'd2 * mag_b),
                                                neg, ovf);
                        r.overflow = ovf;
                    end
                end
                OP_GT:       r.compare_true = (a > b);
                OP_LT:       r.compare_true = (a < b);
                OP_GE:       r.compare_true = (a >= b);
                OP_LE:       r.compare_true = (a <= b);
                OP_EQ:       r.compare_true = (a == b);
                OP_NE:       r.compare_true = (a != b);
                OP_MIN:      r.result = (a < b) ? a : b;
                OP_MAX:      r.result = (a > b) ? a : b;
                OP_INC:      r.result = a + 32'sd1;
                OP_DEC:      r.result = a - 32'sd1;
                OP_FROM_INT: r.result = a <<< FRAC;
                OP_TO_INT:   r.result = a >>> FRAC;
                default:     r = '0;
            endcase
            return r;
        endfunction

        function void note_operation(input fpa_in_t x);
            pending_results.push_back(alu_result_of(x));
        endfunction

        function void check_result(input fpa_out_t got);
            fpa_out_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: result %0d", got.result);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.result !== want.result) begin
                $error("result mismatch: expected %0d, actual %0d", want.result, got.result);
                mismatches++;
            end
            if (got.compare_true !== want.compare_true) begin
                $error("compare_true mismatch: expected %0b, actual %0b",
                       want.compare_true, got.compare_true);
                mismatches++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow mismatch: expected %0b, actual %0b",
                       want.overflow, got.overflow);
                mismatches++;
            end
            if (got.divide_by_zero !== want.divide_by_zero) begin
                $error("divide_by_zero mismatch: expected %0b, actual %0b",
                       want.divide_by_zero, got.divide_by_zero);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    fpa_in_t   s_payload;
    logic      m_valid;
    logic      m_ready;
    fpa_out_t  m_payload;

    alu_result_tracker tracker = new();

    // Idle/stall percentages for the current phase, owned by the main process.
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_stall_pct  = 0;
    // Long receiver hold-offs: requested by the main process, served by the
    // receiver process, which counts the cycles itself.
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    bit          drain_timeout = 1'b0;

    fixed_point_alu i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the handshake locks up.
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic fpa_in_t make_op(input fpa_op_t op,
                                        input logic signed [DATA_W-1:0] a,
                                        input logic signed [DATA_W-1:0] b);
        fpa_in_t x;
        x.operation = op;
        x.operand_a = a;
        x.operand_b = b;
        return x;
    endfunction

    // Operand mix: full-range noise, values around the fixed-point scale and
    // the corners where wrapping and saturation happen.
    function automatic logic signed [DATA_W-1:0] random_operand();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $signed(32'($urandom_range(0, 32'h1_FFFF))) - 32'sh1_0000;
            6:          v = $signed(32'($urandom_range(0, 32'h1FF_FFFF))) - 32'sh100_0000;
            7: begin
                case ($urandom_range(0, 5))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = 32'sh8000_0001;
                    3:       v = 32'sh7FFF_FF00;
                    4:       v = 32'sh0080_0000;
                    default: v = -32'sh0080_0000;
                endcase
            end
            8:       v = $signed(32'($urandom_range(0, 2047))) - 32'sd1024;
            default: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'sd0;
                    1:       v = 32'sd1;
                    2:       v = -32'sd1;
                    3:       v = 32'sd256;
                    default: v = -32'sd256;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic fpa_in_t random_operation();
        fpa_in_t x;
        // lean on multiply and divide, where rounding and saturation live
        if ($urandom_range(0, 9) < 3)
            x.operation = $urandom_range(0, 1) ? OP_MUL : OP_DIV;
        else
            x.operation = fpa_op_t'(4'($urandom_range(0, 15)));
        x.operand_a = random_operand();
        x.operand_b = random_operand();
        if ($urandom_range(0, 9) == 0)
            x.operand_b = x.operand_a;
        if (x.operation == OP_DIV && $urandom_range(0, 19) == 0)
            x.operand_b = '0;
        return x;
    endfunction

    // Offer one transaction, with random idle cycles ahead of it, and hold it
    // until it is taken.
    task automatic send_operation(input fpa_in_t x);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= x;
        do @(posedge aclk); while (!s_ready);
        tracker.note_operation(x);
    endtask

    // Drop valid and hold until every expected result has come back, or until DRAIN_LIMIT runs out, flagging a timeout.
    task automatic wait_for_drain();
        int unsigned cycles;
        cycles = 0;
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0 && cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        if (tracker.outstanding() != 0)
            drain_timeout = 1'b1;
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count) send_operation(random_operation());
    endtask

    // Receiver: check every result transaction, then pick m_ready for the
    // next cycle. Values read here are the ones sampled at this edge.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                tracker.check_result(m_payload);
            if (hold_left == 0 && hold_served < hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Main sequence: reset, directed corners, then random phases with
    // different idle patterns.
    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        m_ready   <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: wrap, saturation, rounding ties, divide by zero, every op
        send_operation(make_op(OP_ADD, 32'sh7FFF_FFFF, 32'sd1));
        send_operation(make_op(OP_SUB, 32'sh8000_0000, 32'sd1));
        send_operation(make_op(OP_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_operation(make_op(OP_MUL, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_operation(make_op(OP_MUL, 32'sh8000_0000, -32'sd256));
        send_operation(make_op(OP_MUL, 32'sh8000_0000, 32'sd256));
        send_operation(make_op(OP_MUL, 32'sd1, 32'sd128));
        send_operation(make_op(OP_MUL, -32'sd1, 32'sd128));
        send_operation(make_op(OP_DIV, 32'sd1234, 32'sd0));
        send_operation(make_op(OP_DIV, 32'sh8000_0000, -32'sd256));
        send_operation(make_op(OP_DIV, 32'sh8000_0000, 32'sd256));
        send_operation(make_op(OP_DIV, 32'sh7FFF_FFFF, 32'sd1));
        send_operation(make_op(OP_DIV, 32'sd1, 32'sd512));
        send_operation(make_op(OP_DIV, -32'sd1, 32'sd512));
        send_operation(make_op(OP_GT, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_operation(make_op(OP_LT, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_operation(make_op(OP_GE, -32'sd5, -32'sd5));
        send_operation(make_op(OP_LE, 32'sd7, -32'sd7));
        send_operation(make_op(OP_EQ, 32'sh8000_0000, 32'sh8000_0000));
        send_operation(make_op(OP_NE, 32'sd42, 32'sd42));
        send_operation(make_op(OP_MIN, -32'sd300, -32'sd300));
        send_operation(make_op(OP_MAX, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_operation(make_op(OP_INC, 32'sh7FFF_FFFF, 32'sh8000_0000));
        send_operation(make_op(OP_DEC, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_operation(make_op(OP_FROM_INT, 32'sh0080_0001, 32'sd0));
        send_operation(make_op(OP_TO_INT, -32'sd1, 32'sd0));
        send_operation(make_op(OP_TO_INT, 32'sh8000_0000, 32'sd0));
        wait_for_drain();

        // back to back on both sides
        run_random(350);
        wait_for_drain();

        tx_idle_pct = 81;
        run_random(350);
        wait_for_drain();

        // long receiver hold-off while the sender keeps pushing: the pipeline
        // fills and s_ready must drop; then a stalling receiver
        tx_idle_pct   = 0;
        rx_stall_pct  = 81;
        hold_requests = hold_requests + 1;
        run_random(350);
        wait_for_drain();

        tx_idle_pct  = 15;
        rx_stall_pct = 15;
        run_random(400);
        wait_for_drain();

        // mixed stretches, idle pattern changing every few dozen transactions
        repeat (8) begin
            case ($urandom_range(0, 3))
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
            endcase
            run_random(50);
        end

        rx_stall_pct = 0;
        wait_for_drain();
        // catch any stray transaction the block might still emit
        repeat (LATENCY + 20) @(posedge aclk);

        if (!drain_timeout && tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
